FILE: hdl/bsv_pkg.sv
`timescale 1ns / 1ps
package bsv_pkg;

  localparam int VAL_W      = 32;
  localparam int REM_W      = 33;
  localparam int NUM_DIGITS = 10;
  localparam int DIG_IDX_W  = 4;
  localparam int DEF_MAX_DECIMALS = 4;

  localparam logic [2:0] OP_PRESS   = 3'd0;
  localparam logic [2:0] OP_KEY_UP  = 3'd1;
  localparam logic [2:0] OP_KEY_DN  = 3'd2;
  localparam logic [2:0] OP_RELEASE = 3'd3;
  localparam logic [2:0] OP_SET     = 3'd4;
  localparam logic [2:0] OP_RENDER  = 3'd5;

  localparam logic [2:0] REG_MIN    = 3'd0;
  localparam logic [2:0] REG_MAX    = 3'd1;
  localparam logic [2:0] REG_STEP   = 3'd2;
  localparam logic [2:0] REG_WRAP   = 3'd3;
  localparam logic [2:0] REG_DEC    = 3'd4;
  localparam logic [2:0] REG_LEFT   = 3'd5;
  localparam logic [2:0] REG_RIGHT  = 3'd6;
  localparam logic [2:0] REG_HEIGHT = 3'd7;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_POINT = 7'h2e;
  localparam logic [6:0] CHAR_NONE  = 7'h00;

  // multiply by this and drop 17 bits: exact divide by three up to 2^17
  localparam logic [16:0] THIRD_RECIP = 17'd43691;

endpackage

FILE: hdl/bsv_rem.sv
`timescale 1ns / 1ps
module bsv_rem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bsv_pkg::REM_W-1:0] dividend_i,
  input  logic [bsv_pkg::REM_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [bsv_pkg::REM_W-1:0] rem_o
);
  import bsv_pkg::*;

  localparam int CNT_W = $clog2(REM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0] shf_q, shf_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [REM_W-1:0] div_q, div_d;
  logic [REM_W:0]   trial;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem_q, shf_q[REM_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    shf_d  = shf_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      shf_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      shf_d = {shf_q[REM_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = REM_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[REM_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(REM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: hdl/bounded_stepper_value_with_decimal_text.sv
`timescale 1ns / 1ps
// Channel  | handshake               | payload
// in       | in_valid_i / in_stall_o | opcode, touch_x, touch_valid, new_value
// out      | out_valid_o/ out_stall_i| char_code, last_char, status fields
// cfg      | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// A step that wraps adds a pass through the bit-serial remainder unit. A render
// runs the 32-step binary to BCD shift, then emits the characters and steps
// over each suppressed zero.
// Reset clears the registers to their defaults and the value to zero.
// One request is worked at a time; a finished result waits in the output
// register under stall while the next request is taken.
module bounded_stepper_value_with_decimal_text #(
  parameter int MAX_DECIMALS = bsv_pkg::DEF_MAX_DECIMALS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         opcode_i,
  input  logic signed [15:0] touch_x_i,
  input  logic               touch_valid_i,
  input  logic signed [31:0] new_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [6:0]         char_code_o,
  output logic               last_char_o,
  output logic signed [31:0] current_value_o,
  output logic               redraw_o,
  output logic               dec_disabled_o,
  output logic               inc_disabled_o,
  output logic               is_pressed_o,
  output logic signed [1:0]  side_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import bsv_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLAMP = 8'b0000_0010,
    S_ACT   = 8'b0000_0100,
    S_STEP  = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_FIN   = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_TEXT  = 8'b1000_0000
  } state_e;
  // binary to BCD conversion runs inside S_FIN's successor, tracked by conv_q
  state_e state_q, state_d;

  // configuration registers
  logic signed [31:0] min_q, max_q;
  logic [30:0]        step_q;
  logic               wrap_q;
  logic [2:0]         dec_q;
  logic signed [15:0] left_q, right_q;
  logic [14:0]        height_q;

  // values derived from configuration, refreshed every cycle
  logic signed [31:0] lo_q, hi_q;
  logic [REM_W-1:0]   span_q;
  logic               wrap_ok_q;
  logic [14:0]        third_q;
  logic [DIG_IDX_W-1:0] dec_sat_q;

  // request and block state
  logic [2:0]         op_q;
  logic signed [15:0] tx_q;
  logic               tv_q;
  logic signed [31:0] nv_q;
  logic signed [31:0] old_v_q;
  logic               old_p_q;
  logic signed [1:0]  old_z_q;
  logic signed [31:0] value_q, value_d;
  logic               pressed_q, pressed_d;
  logic signed [1:0]  zone_q, zone_d;
  logic signed [1:0]  side_q, side_d;
  logic signed [33:0] sum_q, sum_d;
  logic               up_q, up_d;
  logic               redraw_q, redraw_d;

  // text generation
  logic                 conv_q, conv_d;
  logic [4:0]           cnt_q, cnt_d;
  logic [31:0]          bin_q, bin_d;
  logic [4*NUM_DIGITS-1:0] bcd_q, bcd_d, bcd_adj;
  logic [DIG_IDX_W-1:0] dig_q, dig_d;
  logic                 started_q, started_d;
  logic                 sign_q, sign_d;
  logic                 dot_q, dot_d;

  // output register
  logic               ov_q, ov_d;
  logic [6:0]         ch_q, ch_d;
  logic               last_q, last_d;
  logic signed [31:0] cv_q, cv_d;
  logic               rd_q, rd_d, dd_q, dd_d, id_q, id_d, pr_q, pr_d;
  logic signed [1:0]  sd_q, sd_d;

  logic               accept, out_free;
  logic               rem_start, rem_done;
  logic [REM_W-1:0]   rem_dividend, rem_val;

  logic signed [17:0] width_w, bw_w, lft_w, rgt_w, px_w;
  logic [33:0]        prod_w;
  logic [14:0]        bw_min, bw_u;
  logic signed [33:0] lo34, hi34, st34;
  logic signed [1:0]  zone_w;
  logic [3:0]         digit_w;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !ov_q || !out_stall_i;

  // width of a button zone: a third of the widget, capped by its height, at least one
  assign width_w = 18'(right_q) - 18'(left_q) + 18'sd1;
  assign prod_w  = {17'd0, width_w[16:0]} * {17'd0, THIRD_RECIP};
  assign bw_min  = (height_q < third_q) ? height_q : third_q;
  assign bw_u    = (bw_min == '0) ? 15'd1 : bw_min;
  assign bw_w    = $signed({3'b000, bw_u});
  assign lft_w   = 18'(left_q) + bw_w;
  assign rgt_w   = 18'(right_q) - bw_w + 18'sd1;
  assign px_w    = 18'(tx_q);
  assign zone_w  = !tv_q ? 2'sd0 : (px_w < lft_w) ? -2'sd1 : (px_w >= rgt_w) ? 2'sd1 : 2'sd0;

  assign lo34 = 34'(lo_q);
  assign hi34 = 34'(hi_q);
  assign st34 = (step_q == '0) ? 34'sd1 : $signed({3'b000, step_q});

  assign rem_dividend = (sum_q > hi34) ? REM_W'(sum_q - lo34) : REM_W'(hi34 - sum_q);
  assign digit_w      = bcd_q[{dig_q, 2'b00} +: 4];

  function automatic logic signed [31:0] clamp_fn(input logic signed [31:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    logic signed [31:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

  // add three to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      else bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
    end
  end

  bsv_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .divisor_i  (span_q),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  always_comb begin
    state_d   = state_q;
    value_d   = value_q;
    pressed_d = pressed_q;
    zone_d    = zone_q;
    side_d    = side_q;
    sum_d     = sum_q;
    up_d      = up_q;
    redraw_d  = redraw_q;
    conv_d    = conv_q;
    cnt_d     = cnt_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    dig_d     = dig_q;
    started_d = started_q;
    sign_d    = sign_q;
    dot_d     = dot_q;
    rem_start = 1'b0;
    ov_d   = ov_q && out_stall_i;
    ch_d   = ch_q;
    last_d = last_q;
    cv_d   = cv_q;
    rd_d   = rd_q;
    dd_d   = dd_q;
    id_d   = id_q;
    pr_d   = pr_q;
    sd_d   = sd_q;

    // load one result with the current status
    if (out_free && ((state_q == S_EMIT) || ((state_q == S_TEXT) && !conv_q &&
        (sign_q || dot_q || started_q || dig_q <= dec_sat_q || digit_w != 4'd0)))) begin
      ov_d = 1'b1;
      cv_d = value_q;
      rd_d = redraw_q;
      dd_d = !wrap_q && (value_q <= lo_q);
      id_d = !wrap_q && (value_q >= hi_q);
      pr_d = pressed_q;
      sd_d = zone_q;
      ch_d = CHAR_NONE;
      last_d = 1'b0;
      if (state_q == S_EMIT) begin
        last_d = 1'b1;
      end else if (sign_q) begin
        ch_d = CHAR_MINUS;
      end else if (dot_q) begin
        ch_d = CHAR_POINT;
      end else begin
        ch_d   = CHAR_ZERO + {3'b000, digit_w};
        last_d = (dig_q == '0);
      end
    end

    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_CLAMP;
      end
      S_CLAMP: begin
        value_d = clamp_fn(value_q, lo_q, hi_q);
        side_d  = zone_w;
        state_d = S_ACT;
      end
      S_ACT: begin
        state_d = S_FIN;
        case (op_q)
          OP_PRESS: begin
            zone_d = side_q;
            if (side_q != 2'sd0) begin
              pressed_d = 1'b1;
              sum_d = (side_q > 2'sd0) ? 34'(value_q) + st34 : 34'(value_q) - st34;
              state_d = S_STEP;
            end
          end
          OP_KEY_UP: begin
            sum_d = 34'(value_q) + st34;
            state_d = S_STEP;
          end
          OP_KEY_DN: begin
            sum_d = 34'(value_q) - st34;
            state_d = S_STEP;
          end
          OP_RELEASE: begin
            pressed_d = 1'b0;
            zone_d = 2'sd0;
          end
          OP_SET: value_d = clamp_fn(nv_q, lo_q, hi_q);
          default: ;
        endcase
      end
      S_STEP: begin
        if (wrap_ok_q && ((sum_q > hi34) || (sum_q < lo34))) begin
          rem_start = 1'b1;
          up_d    = (sum_q > hi34);
          state_d = S_DIV;
        end else begin
          if (sum_q > hi34) value_d = hi_q;
          else if (sum_q < lo34) value_d = lo_q;
          else value_d = sum_q[31:0];
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        if (rem_done) begin
          if (up_q) value_d = 32'(34'(lo_q) + $signed({1'b0, rem_val}));
          else value_d = 32'(34'(hi_q) - $signed({1'b0, rem_val}));
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        redraw_d = (value_q != old_v_q) || (pressed_q != old_p_q) || (zone_q != old_z_q);
        if (op_q == OP_RENDER) begin
          conv_d    = 1'b1;
          cnt_d     = '0;
          bin_d     = value_q[31] ? 32'(0 - value_q) : value_q;
          bcd_d     = '0;
          state_d   = S_TEXT;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      S_TEXT: begin
        if (conv_q) begin
          // shift one binary bit into the BCD digits
          bcd_d = {bcd_adj[4*NUM_DIGITS-2:0], bin_q[31]};
          bin_d = {bin_q[30:0], 1'b0};
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == 5'd31) conv_d = 1'b0;
        end else if (sign_q) begin
          if (out_free) sign_d = 1'b0;
        end else if (dot_q) begin
          if (out_free) dot_d = 1'b0;
        end else if (!started_q && (dig_q > dec_sat_q) && (digit_w == 4'd0)) begin
          // drop a leading zero of the integer part
          dig_d = dig_q - 1'b1;
        end else if (out_free) begin
          started_d = 1'b1;
          if ((dig_q == dec_sat_q) && (dec_sat_q != '0)) dot_d = 1'b1;
          if (dig_q == '0) state_d = S_IDLE;
          else dig_d = dig_q - 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      min_q     <= 32'sd0;
      max_q     <= 32'sd100;
      step_q    <= 31'd1;
      wrap_q    <= 1'b0;
      dec_q     <= 3'd0;
      left_q    <= 16'sd0;
      right_q   <= 16'sd0;
      height_q  <= 15'd1;
      value_q   <= 32'sd0;
      pressed_q <= 1'b0;
      zone_q    <= 2'sd0;
      conv_q    <= 1'b0;
      sign_q    <= 1'b0;
      dot_q     <= 1'b0;
      started_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      value_q   <= value_d;
      pressed_q <= pressed_d;
      zone_q    <= zone_d;
      conv_q    <= conv_d;
      ov_q      <= ov_d;
      if (state_q == S_FIN) begin
        sign_q    <= value_q[31];
        dot_q     <= 1'b0;
        started_q <= 1'b0;
      end else begin
        sign_q    <= sign_d;
        dot_q     <= dot_d;
        started_q <= started_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MIN:    min_q    <= cfg_data_i;
          REG_MAX:    max_q    <= cfg_data_i;
          REG_STEP:   step_q   <= cfg_data_i[30:0];
          REG_WRAP:   wrap_q   <= cfg_data_i[0];
          REG_DEC:    dec_q    <= cfg_data_i[2:0];
          REG_LEFT:   left_q   <= cfg_data_i[15:0];
          REG_RIGHT:  right_q  <= cfg_data_i[15:0];
          REG_HEIGHT: height_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // bounds in order, span and zone width are registered from the configuration registers
    lo_q      <= (min_q < max_q) ? min_q : max_q;
    hi_q      <= (min_q < max_q) ? max_q : min_q;
    span_q    <= (min_q < max_q) ? REM_W'(33'(max_q) - 33'(min_q) + 33'sd1)
                                 : REM_W'(33'(min_q) - 33'(max_q) + 33'sd1);
    wrap_ok_q <= wrap_q && (min_q != max_q);
    third_q   <= (width_w > 18'sd0) ? prod_w[31:17] : 15'd0;
    dec_sat_q <= ({1'b0, dec_q} > DIG_IDX_W'(MAX_DECIMALS)) ? DIG_IDX_W'(MAX_DECIMALS)
                                                            : {1'b0, dec_q};
    if (accept) begin
      op_q    <= opcode_i;
      tx_q    <= touch_x_i;
      tv_q    <= touch_valid_i;
      nv_q    <= new_value_i;
      old_v_q <= value_q;
      old_p_q <= pressed_q;
      old_z_q <= zone_q;
    end
    side_q   <= side_d;
    sum_q    <= sum_d;
    up_q     <= up_d;
    redraw_q <= redraw_d;
    cnt_q    <= cnt_d;
    bin_q    <= bin_d;
    bcd_q    <= bcd_d;
    dig_q    <= (state_q == S_FIN) ? DIG_IDX_W'(NUM_DIGITS - 1) : dig_d;
    ch_q     <= ch_d;
    last_q   <= last_d;
    cv_q     <= cv_d;
    rd_q     <= rd_d;
    dd_q     <= dd_d;
    id_q     <= id_d;
    pr_q     <= pr_d;
    sd_q     <= sd_d;
  end

  assign out_valid_o     = ov_q;
  assign char_code_o     = ch_q;
  assign last_char_o     = last_q;
  assign current_value_o = cv_q;
  assign redraw_o        = rd_q;
  assign dec_disabled_o  = dd_q;
  assign inc_disabled_o  = id_q;
  assign is_pressed_o    = pr_q;
  assign side_o          = sd_q;

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state register not one-hot");
  a_accept_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_CLAMP)
    else $error("accepted request did not start");
  a_zone_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zone_q != 2'sd0 |-> pressed_q)
    else $error("active zone without press");
  a_side_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> side_o != 2'b10)
    else $error("side out of range");
`endif

endmodule
